FILE: rtl/four_cable_planar_kinematics_defines.svh
// Assertion macros for the four-cable planar kinematics block.
// Taken in by the checker; depends on nothing else.
`ifndef FOUR_CABLE_PLANAR_KINEMATICS_DEFINES_SVH
`define FOUR_CABLE_PLANAR_KINEMATICS_DEFINES_SVH

// same-cycle implication under reset
`define FCPK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define FCPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fcpk_pkg.sv
// Shared types, codes and iteration steps for the four-cable planar kinematics.
// Used by the top level and its checker; depends on nothing.
`default_nettype none

package fcpk_pkg;

  localparam int unsigned IterStages = 16;

  localparam logic ReqInverse = 1'b0;
  localparam logic ReqForward = 1'b1;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusOutside = 2'd1;
  localparam logic [1:0] StatusNoMeet  = 2'd2;

  // register indexes; byte address is 4 * index
  localparam logic [1:0] RegFrameW = 2'd0;
  localparam logic [1:0] RegFrameH = 2'd1;
  localparam logic [1:0] RegEffW   = 2'd2;
  localparam logic [1:0] RegEffH   = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] line_length_1;
    logic [31:0] line_length_2;
    logic [31:0] line_length_3;
    logic [31:0] line_length_4;
  } fcpk_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic [31:0]        result_length_1;
    logic [31:0]        result_length_2;
    logic [31:0]        result_length_3;
    logic [31:0]        result_length_4;
  } fcpk_out_t;

  // square root state: remaining radicand and partial root
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sq_t;

  // restoring divide state: partial remainder, dividend bits left, quotient
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] lo;
    logic [31:0] quo;
  } dv_t;

  function automatic sq_t sq_step(sq_t s, logic [63:0] b);
    sq_t         o;
    logic [63:0] t;
    t = s.root + b;
    if (s.rem >= t) begin
      o.rem  = s.rem - t;
      o.root = (s.root >> 1) + b;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  function automatic dv_t dv_step(dv_t s, logic [33:0] dvs);
    dv_t         o;
    logic [33:0] sh;
    sh   = {s.rem[32:0], s.lo[31]};
    o.lo = {s.lo[30:0], 1'b0};
    if (sh >= dvs) begin
      o.rem = sh - dvs;
      o.quo = {s.quo[30:0], 1'b1};
    end else begin
      o.rem = sh;
      o.quo = {s.quo[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/four_cable_planar_kinematics.sv
// Top level of the four-cable planar kinematics: config registers and the
// full compute pipeline. Depends on fcpk_pkg.
//
//   channel  | dir | handshake             | beat
//   ---------+-----+-----------------------+---------------------------
//   in       | in  | in_valid_i/in_stall_o | fcpk_pkg::fcpk_in_t
//   out      | out | out_valid_o/out_stall_i| fcpk_pkg::fcpk_out_t
//   config   | in  | psel/penable/pready   | 32-bit register, addr 4*i
//
// One beat enters per cycle while in_stall_o is low.
// The pipeline holds two 16-stage segments (divide plus inverse roots,
// then forward roots), each stage doing two steps of a bit-serial loop.
// A stalled output beat freezes every stage; nothing is dropped or repeated.
// Reset clears the valid bits and loads the register defaults.
`default_nettype none

module four_cable_planar_kinematics (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire fcpk_pkg::fcpk_in_t in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output fcpk_pkg::fcpk_out_t  out_data_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [3:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned NS = fcpk_pkg::IterStages;

  typedef struct packed {
    logic        req;
    logic        outside;
    logic        fail;
    logic [32:0] ul, ur, vl, vu;
    logic [31:0] dabs;
    logic        dneg;
    logic        dpos;
    logic [31:0] l1, l2, l3, l4;
  } st1_t;

  typedef struct packed {
    logic              req;
    logic              outside;
    logic              fail;
    logic [1:0]        odd_u, odd_v;
    logic [1:0][31:0]  pu, pv;
    logic [1:0][63:0]  su, sv;
    logic [1:0][63:0]  s0, s1;
    logic [63:0]       dd;
    logic [31:0]       dabs;
    logic              dneg;
    logic              dpos;
    logic [1:0][31:0]  r0;
  } st2_t;

  typedef struct packed {
    logic                   req;
    logic                   outside;
    logic                   fail;
    logic [3:0]             sat;
    fcpk_pkg::sq_t [3:0]    sq;
    fcpk_pkg::dv_t [1:0]    dv;
    logic [1:0]             neg;
    logic [33:0]            dvs;
    logic                   dpos;
    logic [1:0][31:0]       r0;
    logic [1:0][63:0]       s0;
  } sa_t;

  typedef struct packed {
    logic              req;
    logic              outside;
    logic              fail;
    logic [3:0][31:0]  len;
    logic [1:0][31:0]  mag;
    logic [1:0]        neg;
    logic [1:0][63:0]  a2;
    logic [1:0][63:0]  s0;
    logic              dpos;
  } st20_t;

  typedef struct packed {
    logic                   req;
    logic                   outside;
    logic                   fail;
    logic [3:0][31:0]       len;
    logic [1:0][31:0]       mag;
    logic [1:0]             neg;
    logic                   dpos;
    fcpk_pkg::sq_t [1:0]    sq;
  } sb_t;

  function automatic logic pair_fail(logic [31:0] r0, logic [31:0] r1, logic [31:0] d);
    logic [32:0] sum;
    logic [31:0] diff;
    sum  = {1'b0, r0} + {1'b0, r1};
    diff = (r0 > r1) ? (r0 - r1) : (r1 - r0);
    return (d == 32'd0) || ({1'b0, d} > sum) || (d < diff);
  endfunction

  function automatic logic signed [31:0] half_sat(logic signed [35:0] v);
    logic signed [35:0] h;
    h = v >>> 1;
    if (h > 36'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (h < -36'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return h[31:0];
  endfunction

  // ---------------- config ----------------
  logic [31:0] frame_width_q, frame_height_q, effector_width_q, effector_height_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q     <= 32'h0001_0000;
      frame_height_q    <= 32'h0001_0000;
      effector_width_q  <= 32'd0;
      effector_height_q <= 32'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        fcpk_pkg::RegFrameW: frame_width_q     <= pwdata;
        fcpk_pkg::RegFrameH: frame_height_q    <= pwdata;
        fcpk_pkg::RegEffW:   effector_width_q  <= pwdata;
        fcpk_pkg::RegEffH:   effector_height_q <= pwdata;
        default:             frame_width_q     <= frame_width_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fcpk_pkg::RegFrameW: prdata = frame_width_q;
      fcpk_pkg::RegFrameH: prdata = frame_height_q;
      fcpk_pkg::RegEffW:   prdata = effector_width_q;
      fcpk_pkg::RegEffH:   prdata = effector_height_q;
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------- flow ----------------
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- stage 0: input register ----------------
  fcpk_pkg::fcpk_in_t in_q;
  logic               v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) in_q <= in_data_i;
  end

  // ---------------- stage 1: offsets and workspace checks ----------------
  logic signed [34:0] xx, yy, ew_s, eh_s, xr, yt, ul_w, ur_w, vl_w, vu_w;
  logic signed [32:0] dxs;
  logic [32:0]        dabs_w;
  st1_t               st1_d, st1_q;
  logic               v1_q;

  always_comb begin
    xx     = $signed({2'b00, in_q.target_x, 1'b0});
    yy     = $signed({2'b00, in_q.target_y, 1'b0});
    ew_s   = $signed({3'b000, effector_width_q});
    eh_s   = $signed({3'b000, effector_height_q});
    xr     = $signed({2'b00, frame_width_q, 1'b0}) - ew_s;
    yt     = $signed({2'b00, frame_height_q, 1'b0}) - eh_s;
    ul_w   = xx - ew_s;
    ur_w   = xr - xx;
    vl_w   = yy - eh_s;
    vu_w   = yt - yy;
    dxs    = $signed({1'b0, frame_width_q}) - $signed({1'b0, effector_width_q});
    dabs_w = dxs[32] ? 33'(-dxs) : 33'(dxs);

    st1_d.req     = in_q.req_type;
    st1_d.outside = (xx < ew_s) || (yy < eh_s) || (xx > xr) || (yy > yt);
    st1_d.ul      = ul_w[32:0];
    st1_d.ur      = ur_w[32:0];
    st1_d.vl      = vl_w[32:0];
    st1_d.vu      = vu_w[32:0];
    st1_d.dabs    = dabs_w[31:0];
    st1_d.dneg    = dxs[32];
    st1_d.dpos    = !dxs[32] && (dxs != 33'sd0);
    st1_d.fail    = pair_fail(in_q.line_length_1, in_q.line_length_3, dabs_w[31:0]) ||
                    pair_fail(in_q.line_length_2, in_q.line_length_4, dabs_w[31:0]);
    st1_d.l1      = in_q.line_length_1;
    st1_d.l2      = in_q.line_length_2;
    st1_d.l3      = in_q.line_length_3;
    st1_d.l4      = in_q.line_length_4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) st1_q <= st1_d;
  end

  // ---------------- stage 2: squares ----------------
  st2_t st2_d, st2_q;
  logic v2_q;

  always_comb begin
    st2_d.req     = st1_q.req;
    st2_d.outside = st1_q.outside;
    st2_d.fail    = st1_q.fail;
    st2_d.odd_u   = {st1_q.ur[0], st1_q.ul[0]};
    st2_d.odd_v   = {st1_q.vu[0], st1_q.vl[0]};
    st2_d.pu[0]   = st1_q.ul[32:1];
    st2_d.pu[1]   = st1_q.ur[32:1];
    st2_d.pv[0]   = st1_q.vl[32:1];
    st2_d.pv[1]   = st1_q.vu[32:1];
    st2_d.su[0]   = {32'd0, st1_q.ul[32:1]} * {32'd0, st1_q.ul[32:1]};
    st2_d.su[1]   = {32'd0, st1_q.ur[32:1]} * {32'd0, st1_q.ur[32:1]};
    st2_d.sv[0]   = {32'd0, st1_q.vl[32:1]} * {32'd0, st1_q.vl[32:1]};
    st2_d.sv[1]   = {32'd0, st1_q.vu[32:1]} * {32'd0, st1_q.vu[32:1]};
    st2_d.s0[0]   = {32'd0, st1_q.l1} * {32'd0, st1_q.l1};
    st2_d.s1[0]   = {32'd0, st1_q.l3} * {32'd0, st1_q.l3};
    st2_d.s0[1]   = {32'd0, st1_q.l2} * {32'd0, st1_q.l2};
    st2_d.s1[1]   = {32'd0, st1_q.l4} * {32'd0, st1_q.l4};
    st2_d.dd      = {32'd0, st1_q.dabs} * {32'd0, st1_q.dabs};
    st2_d.dabs    = st1_q.dabs;
    st2_d.dneg    = st1_q.dneg;
    st2_d.dpos    = st1_q.dpos;
    st2_d.r0[0]   = st1_q.l1;
    st2_d.r0[1]   = st1_q.l2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) st2_q <= st2_d;
  end

  // ---------------- stage 3: sums, loop setup ----------------
  sa_t              sa_q [NS+1];
  logic [NS:0]      va_q;
  sa_t              sa_init;
  logic [65:0]      acc [4];
  logic [65:0]      num [2];
  logic [65:0]      mag_w [2];

  always_comb begin
    sa_init.req     = st2_q.req;
    sa_init.outside = st2_q.outside;
    sa_init.fail    = st2_q.fail;
    for (int k = 0; k < 4; k++) begin
      // k = 2*u_index + v_index: lengths 1..4 are (ul,vl) (ul,vu) (ur,vl) (ur,vu)
      acc[k] = {2'b00, st2_q.su[k/2]} + {2'b00, st2_q.sv[k%2]} +
               (st2_q.odd_u[k/2] ? {34'd0, st2_q.pu[k/2]} : 66'd0) +
               (st2_q.odd_v[k%2] ? {34'd0, st2_q.pv[k%2]} : 66'd0);
      sa_init.sat[k]     = acc[k][65:64] != 2'b00;
      sa_init.sq[k].rem  = acc[k][63:0];
      sa_init.sq[k].root = 64'd0;
    end
    for (int p = 0; p < 2; p++) begin
      num[p]   = {2'b00, st2_q.s0[p]} + {2'b00, st2_q.dd} - {2'b00, st2_q.s1[p]};
      mag_w[p] = num[p][65] ? (66'd0 - num[p]) : num[p];
      sa_init.neg[p]    = num[p][65] ^ st2_q.dneg;
      sa_init.dv[p].rem = {1'b0, mag_w[p][64:32]};
      sa_init.dv[p].lo  = mag_w[p][31:0];
      sa_init.dv[p].quo = 32'd0;
      sa_init.r0[p]     = st2_q.r0[p];
      sa_init.s0[p]     = st2_q.s0[p];
    end
    sa_init.dvs  = {1'b0, st2_q.dabs, 1'b0};
    sa_init.dpos = st2_q.dpos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q[0] <= 1'b0;
    else if (en) va_q[0] <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) sa_q[0] <= sa_init;
  end

  // ---------------- segment A: divide and inverse roots ----------------
  for (genvar g = 0; g < NS; g++) begin : g_seg_a
    localparam logic [63:0] B0 = 64'd1 << (62 - 4*g);
    localparam logic [63:0] B1 = 64'd1 << (60 - 4*g);
    sa_t nx;

    always_comb begin
      nx = sa_q[g];
      for (int k = 0; k < 4; k++) begin
        nx.sq[k] = fcpk_pkg::sq_step(fcpk_pkg::sq_step(sa_q[g].sq[k], B0), B1);
      end
      for (int p = 0; p < 2; p++) begin
        nx.dv[p] = fcpk_pkg::dv_step(fcpk_pkg::dv_step(sa_q[g].dv[p], sa_q[g].dvs),
                                     sa_q[g].dvs);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) va_q[g+1] <= 1'b0;
      else if (en) va_q[g+1] <= va_q[g];
    end
    always_ff @(posedge clk_i) begin
      if (en) sa_q[g+1] <= nx;
    end
  end

  // ---------------- stage 20: clamp offset, square it ----------------
  st20_t st20_d, st20_q;
  logic  v20_q;

  always_comb begin
    st20_d.req     = sa_q[NS].req;
    st20_d.outside = sa_q[NS].outside;
    st20_d.fail    = sa_q[NS].fail;
    for (int k = 0; k < 4; k++) begin
      st20_d.len[k] = sa_q[NS].sat[k] ? 32'hFFFF_FFFF : sa_q[NS].sq[k].root[31:0];
    end
    for (int p = 0; p < 2; p++) begin
      st20_d.mag[p] = (sa_q[NS].dv[p].quo > sa_q[NS].r0[p]) ? sa_q[NS].r0[p]
                                                            : sa_q[NS].dv[p].quo;
      st20_d.a2[p]  = {32'd0, st20_d.mag[p]} * {32'd0, st20_d.mag[p]};
      st20_d.s0[p]  = sa_q[NS].s0[p];
    end
    st20_d.neg  = sa_q[NS].neg;
    st20_d.dpos = sa_q[NS].dpos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v20_q <= 1'b0;
    else if (en) v20_q <= va_q[NS];
  end
  always_ff @(posedge clk_i) begin
    if (en) st20_q <= st20_d;
  end

  // ---------------- stage 21: radicand for the heights ----------------
  sb_t         sb_q [NS+1];
  logic [NS:0] vb_q;
  sb_t         sb_init;

  always_comb begin
    sb_init.req     = st20_q.req;
    sb_init.outside = st20_q.outside;
    sb_init.fail    = st20_q.fail;
    sb_init.len     = st20_q.len;
    sb_init.mag     = st20_q.mag;
    sb_init.neg     = st20_q.neg;
    sb_init.dpos    = st20_q.dpos;
    for (int p = 0; p < 2; p++) begin
      sb_init.sq[p].rem  = (st20_q.s0[p] >= st20_q.a2[p]) ? (st20_q.s0[p] - st20_q.a2[p])
                                                           : 64'd0;
      sb_init.sq[p].root = 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q[0] <= 1'b0;
    else if (en) vb_q[0] <= v20_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) sb_q[0] <= sb_init;
  end

  // ---------------- segment B: forward heights ----------------
  for (genvar g = 0; g < NS; g++) begin : g_seg_b
    localparam logic [63:0] B0 = 64'd1 << (62 - 4*g);
    localparam logic [63:0] B1 = 64'd1 << (60 - 4*g);
    sb_t nx;

    always_comb begin
      nx = sb_q[g];
      for (int p = 0; p < 2; p++) begin
        nx.sq[p] = fcpk_pkg::sq_step(fcpk_pkg::sq_step(sb_q[g].sq[p], B0), B1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vb_q[g+1] <= 1'b0;
      else if (en) vb_q[g+1] <= vb_q[g];
    end
    always_ff @(posedge clk_i) begin
      if (en) sb_q[g+1] <= nx;
    end
  end

  // ---------------- output stage ----------------
  fcpk_pkg::fcpk_out_t out_d, out_q;
  logic signed [33:0]  aoff [2];
  logic signed [33:0]  dh, dhs;
  logic signed [35:0]  sx, sy;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      aoff[p] = sb_q[NS].neg[p] ? -$signed({2'b00, sb_q[NS].mag[p]})
                                :  $signed({2'b00, sb_q[NS].mag[p]});
    end
    dh  = $signed({2'b00, sb_q[NS].sq[0].root[31:0]}) -
          $signed({2'b00, sb_q[NS].sq[1].root[31:0]});
    dhs = sb_q[NS].dpos ? dh : -dh;
    sx  = $signed({4'b0000, effector_width_q}) + 36'(aoff[0]) + 36'(aoff[1]);
    sy  = $signed({4'b0000, frame_height_q}) + 36'(dhs);

    out_d = '0;
    if (sb_q[NS].req == fcpk_pkg::ReqInverse) begin
      if (sb_q[NS].outside) begin
        out_d.status = fcpk_pkg::StatusOutside;
      end else begin
        out_d.status          = fcpk_pkg::StatusOk;
        out_d.result_length_1 = sb_q[NS].len[0];
        out_d.result_length_2 = sb_q[NS].len[1];
        out_d.result_length_3 = sb_q[NS].len[2];
        out_d.result_length_4 = sb_q[NS].len[3];
      end
    end else if (sb_q[NS].fail) begin
      out_d.status = fcpk_pkg::StatusNoMeet;
    end else begin
      out_d.status   = fcpk_pkg::StatusOk;
      out_d.result_x = half_sat(sx);
      out_d.result_y = half_sat(sy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vb_q[NS];
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/fcpk_checker.sv
// Port-level checker for the four-cable planar kinematics, bound to the top.
// Depends on fcpk_pkg and four_cable_planar_kinematics_defines.svh.
`default_nettype none
`include "four_cable_planar_kinematics_defines.svh"

module fcpk_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_stall_o,
  input wire                      out_valid_o,
  input wire                      out_stall_i,
  input wire fcpk_pkg::fcpk_out_t out_data_o
);

  // hold a stalled output beat
  `FCPK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output beat changed")

  // input stalls exactly when the output beat is held
  `FCPK_ASSERT_NOW(a_stall_link, clk_i, rst_ni, 1'b1, in_stall_o == (out_valid_o && out_stall_i), "input stall does not follow output stall")

  `FCPK_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_o, out_data_o.status == fcpk_pkg::StatusOk || out_data_o.status == fcpk_pkg::StatusOutside || out_data_o.status == fcpk_pkg::StatusNoMeet, "unknown status code")

  // error beats carry nothing but status
  `FCPK_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != fcpk_pkg::StatusOk, out_data_o.result_x == 0 && out_data_o.result_y == 0 && out_data_o.result_length_1 == 0 && out_data_o.result_length_4 == 0, "error beat has nonzero fields")

  // a beat with lengths is an inverse beat
  `FCPK_ASSERT_NOW(a_kind_excl, clk_i, rst_ni, out_valid_o && out_data_o.result_length_1 != 0, out_data_o.result_x == 0 && out_data_o.result_y == 0, "lengths and position in one beat")

endmodule

bind four_cable_planar_kinematics fcpk_checker u_fcpk_checker (.*);

`default_nettype wire
